@@ sv/ped_pkg.sv @@
package ped_pkg;

  localparam int MaxWidth = 4096;
  localparam int PalDepth = 128;
  localparam int XW       = $clog2(MaxWidth);
  localparam int PalAw    = $clog2(PalDepth);
  localparam int ErrW     = 20;
  localparam int DiffW    = 20;
  localparam int WtW      = 26;
  localparam int SqW      = 2 * DiffW;
  localparam int ProdW    = DiffW + WtW;
  localparam int DistW    = SqW + WtW + 2;

  // 512 * 65535 and 1024 * 65535
  localparam logic [WtW-1:0] BaseWt  = 26'd33553920;
  localparam logic [WtW-1:0] GreenWt = 26'd67107840;

  localparam logic OP_PAL   = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_PAL_LEN = 2'd2;

  typedef struct packed {
    logic        op;
    logic [6:0]  entry_index;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] alpha;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic [6:0]  chosen_entry;
    logic        frame_end;
  } out_item_t;

  typedef struct packed {
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
  } color_t;

  typedef struct packed {
    logic [ErrW-1:0] r;
    logic [ErrW-1:0] g;
    logic [ErrW-1:0] b;
  } work_t;

  typedef struct packed {
    logic [ErrW-1:0] right;
    logic [ErrW-1:0] down;
    logic [ErrW-1:0] left;
    logic [ErrW-1:0] diag;
  } share_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_PREAD,
    ST_START,
    ST_WAIT,
    ST_ERR,
    ST_ERR2,
    ST_OUT
  } state_t;

  function automatic logic [ErrW-1:0] sat20(input logic signed [25:0] v);
    if (v > 26'sd524287) return 20'h7FFFF;
    if (v < -26'sd524288) return 20'h80000;
    return v[ErrW-1:0];
  endfunction

  // divide by 16, truncating toward zero
  function automatic logic signed [20:0] div16(input logic signed [24:0] v);
    logic signed [24:0] t;
    t = v + $signed({21'd0, {4{v[24]}}});
    return $signed(t[24:4]);
  endfunction

  function automatic logic [ErrW-1:0] add_sat(input logic [15:0] v,
                                              input logic signed [ErrW-1:0] a,
                                              input logic signed [ErrW-1:0] b);
    logic signed [25:0] s;
    s = $signed({10'd0, v}) + 26'(a) + 26'(b);
    return sat20(s);
  endfunction

  function automatic share_t diffuse(input logic signed [ErrW-1:0] w,
                                     input logic [15:0] p,
                                     input logic signed [ErrW-1:0] carry,
                                     input logic signed [ErrW-1:0] prev);
    logic signed [20:0] d;
    logic signed [24:0] d25;
    share_t s;
    d     = $signed({w[ErrW-1], w}) - $signed({5'd0, p});
    d25   = 25'(d);
    s.right = sat20(26'(div16(d25 * 25'sd7)));
    s.down  = sat20(26'(div16(d25 * 25'sd5)) + 26'(carry));
    s.left  = sat20(26'(prev) + 26'(div16(d25 * 25'sd3)));
    s.diag  = sat20(26'(div16(d25)));
    return s;
  endfunction

  function automatic color_t pal_default(input logic [PalAw-1:0] i);
    color_t c;
    c = '0;
    if (int'(i) == 1) c = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
    if (int'(i) == 2) c.r = 16'hFFFF;
    if (int'(i) == 3) c.g = 16'hFFFF;
    if (int'(i) == 4) c.b = 16'hFFFF;
    return c;
  endfunction

endpackage

@@ sv/ped_ram.sv @@
module ped_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/ped_dist.sv @@
module ped_dist (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  ped_pkg::work_t           w,
  input  ped_pkg::color_t          p,
  output logic                     done,
  output logic [ped_pkg::DistW-1:0] dist_val
);
  import ped_pkg::*;

  logic [3:0]       ph_r, ph_nxt;
  logic             done_r;
  logic [DiffW-1:0] dr_r, dg_r, db_r;
  logic [WtW-1:0]   wr_r, wb_r;
  logic [SqW-1:0]   sqr_r, sqg_r, sqb_r;
  logic [ProdW-1:0] prod_r;
  logic [DistW-1:0] acc_r;
  logic [DiffW-1:0] mul_a;
  logic [WtW-1:0]   mul_b;
  logic signed [20:0] sum_r, m_half;
  logic [DistW-1:0] prod_hi;

  function automatic logic [DiffW-1:0] absd(input logic signed [ErrW-1:0] a,
                                            input logic [15:0] b);
    logic signed [20:0] t;
    t = $signed({a[ErrW-1], a}) - $signed({5'd0, b});
    return t[20] ? DiffW'(-t) : t[DiffW-1:0];
  endfunction

  // redmean term, halved with truncation toward zero
  assign sum_r  = $signed({w.r[ErrW-1], w.r}) + $signed({5'd0, p.r});
  assign m_half = (sum_r + $signed({20'd0, sum_r[20]})) >>> 1;

  always_comb begin
    ph_nxt = ph_r;
    if (ph_r == 4'd0) begin
      if (start) ph_nxt = 4'd1;
    end else if (ph_r == 4'd10) begin
      ph_nxt = 4'd0;
    end else begin
      ph_nxt = ph_r + 4'd1;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ph_r)
      4'd1: begin mul_a = dr_r;             mul_b = WtW'(dr_r); end
      4'd2: begin mul_a = dg_r;             mul_b = WtW'(dg_r); end
      4'd3: begin mul_a = db_r;             mul_b = WtW'(db_r); end
      4'd4: begin mul_a = sqr_r[SqW-1:DiffW]; mul_b = wr_r;     end
      4'd5: begin mul_a = sqr_r[DiffW-1:0];   mul_b = wr_r;     end
      4'd6: begin mul_a = sqg_r[SqW-1:DiffW]; mul_b = GreenWt;  end
      4'd7: begin mul_a = sqg_r[DiffW-1:0];   mul_b = GreenWt;  end
      4'd8: begin mul_a = sqb_r[SqW-1:DiffW]; mul_b = wb_r;     end
      4'd9: begin mul_a = sqb_r[DiffW-1:0];   mul_b = wb_r;     end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_hi = DistW'({prod_r, {DiffW{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= 4'd0;
      done_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      done_r <= (ph_r == 4'd10);
    end
  end

  always_ff @(posedge clk) begin
    if (ph_r == 4'd0 && start) begin
      dr_r <= absd(w.r, p.r);
      dg_r <= absd(w.g, p.g);
      db_r <= absd(w.b, p.b);
      wr_r <= WtW'($signed({1'b0, BaseWt}) + 27'(m_half));
      wb_r <= WtW'($signed({1'b0, BaseWt}) + 27'sd65534 - 27'(m_half));
    end
    prod_r <= {{WtW{1'b0}}, mul_a} * {{DiffW{1'b0}}, mul_b};
    case (ph_r)
      4'd2: sqr_r <= prod_r[SqW-1:0];
      4'd3: sqg_r <= prod_r[SqW-1:0];
      4'd4: sqb_r <= prod_r[SqW-1:0];
      4'd5: acc_r <= prod_hi;
      4'd7, 4'd9: acc_r <= acc_r + prod_hi;
      4'd6, 4'd8, 4'd10: acc_r <= acc_r + DistW'(prod_r);
      default: ;
    endcase
  end

  assign done     = done_r;
  assign dist_val = acc_r;

endmodule

@@ sv/palette_error_diffusion_dither_core.sv @@
// Channel   | Ports                                   | Transaction
// ----------+-----------------------------------------+-----------------------------------
// input     | in_valid, in_stall, in_data             | palette write or one RGBA pixel
// result    | out_valid, out_stall, out_data          | chosen color, alpha, index, frame end
// config    | psel, penable, pwrite, paddr, pwdata,   | width, height, palette length
//           | prdata, pready                          |
//
// A palette write is taken in the idle state and does not stall the input. For each
// searched palette entry a pixel passes through one palette RAM read, one start step,
// the steps of the shared 20x26 multiplier and one step to hand back the distance;
// per pixel there is also one error sum, two error write-back steps, one output step
// and one idle step that takes the next.
// After reset, a clearing pass zeroes every entry of the next-row error RAM,
// with in_stall held high; configuration writes are taken meanwhile.
// The result sits in an output register, so a finished pixel waiting on out_stall
// does not block the next transaction from being accepted.
module palette_error_diffusion_dither_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ped_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ped_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ped_pkg::*;

  state_t state_r, state_nxt;

  // configuration registers
  logic [12:0] width_r;
  logic [15:0] height_r;
  logic [7:0]  len_r;

  // raster position
  logic [XW-1:0] col_r;
  logic [15:0]   row_r;
  logic [XW-1:0] clr_r;

  // pixel in flight
  in_item_t pix_r;
  work_t    work_r, rerr_r, carry_r, prev_r, xm1_r;

  // palette search
  logic [PalAw-1:0] idx_r, best_idx_r;
  color_t           cur_col_r, best_col_r, pal_col;
  logic [DistW-1:0] best_d_r, dist_val;
  logic             dist_done, dist_start;
  logic             pal_vld_r [PalDepth];
  logic             pal_rvld_r;
  logic [47:0]      pal_rdata;
  logic             pal_we;

  // next-row error RAM
  logic             nre_we;
  logic [XW-1:0]    nre_waddr;
  work_t            nre_wdata, nre_rdata;

  logic             out_valid_r;
  out_item_t        out_r;

  logic             accept, cfg_wr, out_free;
  logic [16:0]      w17;
  logic [XW:0]      w_eff, col_p1;
  logic [15:0]      h_eff;
  logic [8:0]       n9;
  logic [PalAw:0]   n_eff;
  logic             last_col, last_row, last_idx;
  share_t           sh_r, sh_g, sh_b;
  work_t            down_v;

  assign accept   = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite;
  assign out_free = !out_valid_r || !out_stall;
  assign pready   = 1'b1;

  // Clamp out-of-range settings to usable values.
  assign w17    = (width_r == 13'd0) ? 17'd1 :
                  ((17'(width_r) > 17'(MaxWidth)) ? 17'(MaxWidth) : 17'(width_r));
  assign w_eff  = (XW+1)'(w17);
  assign h_eff  = (height_r == 16'd0) ? 16'd1 : height_r;
  assign n9     = (len_r == 8'd0) ? 9'd1 :
                  ((9'(len_r) > 9'(PalDepth)) ? 9'(PalDepth) : 9'(len_r));
  assign n_eff  = (PalAw+1)'(n9);
  assign col_p1 = {1'b0, col_r} + (XW+1)'(1);
  assign last_col = col_p1 >= w_eff;
  assign last_row = ({1'b0, row_r} + 17'd1) >= {1'b0, h_eff};
  assign last_idx = ({1'b0, idx_r} + (PalAw+1)'(1)) >= n_eff;

  // Entries never written read as the power-on palette.
  assign pal_col = pal_rvld_r ? color_t'(pal_rdata) : pal_default(idx_r);

  // Error shares for each channel against the chosen color.
  assign sh_r = diffuse(work_r.r, best_col_r.r, carry_r.r, prev_r.r);
  assign sh_g = diffuse(work_r.g, best_col_r.g, carry_r.g, prev_r.g);
  assign sh_b = diffuse(work_r.b, best_col_r.b, carry_r.b, prev_r.b);
  assign down_v = last_row ? work_t'('0) : work_t'{sh_r.down, sh_g.down, sh_b.down};

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == XW'(MaxWidth - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept && in_data.op == OP_PIXEL) state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_PREAD;
      ST_PREAD: state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (dist_done) state_nxt = last_idx ? ST_ERR : ST_PREAD;
      end
      ST_ERR:   state_nxt = ST_ERR2;
      ST_ERR2:  state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // ---------------- state outputs ----------------
  always_comb begin
    in_stall   = 1'b1;
    dist_start = 1'b0;
    pal_we     = 1'b0;
    nre_we     = 1'b0;
    nre_waddr  = col_r;
    nre_wdata  = '0;
    unique case (state_r)
      ST_CLEAR: begin
        nre_we    = 1'b1;
        nre_waddr = clr_r;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        pal_we   = in_valid && in_data.op == OP_PAL &&
                   int'(in_data.entry_index) < PalDepth;
      end
      ST_START: dist_start = 1'b1;
      ST_ERR: begin
        nre_we    = 1'b1;
        nre_wdata = down_v;
      end
      ST_ERR2: begin
        // down-left share lands in the previous column of the next-row error RAM
        nre_we    = !last_row && col_r != '0;
        nre_waddr = col_r - XW'(1);
        nre_wdata = xm1_r;
      end
      ST_SUM, ST_PREAD, ST_WAIT, ST_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      width_r     <= 13'd1;
      height_r    <= 16'd1;
      len_r       <= 8'd5;
      col_r       <= '0;
      row_r       <= '0;
      rerr_r      <= '0;
      carry_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PalDepth; i++) pal_vld_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_r <= clr_r + XW'(1);

      if (cfg_wr) begin
        unique case (paddr[3:2])
          REG_WIDTH:   width_r  <= pwdata[12:0];
          REG_HEIGHT:  height_r <= pwdata[15:0];
          REG_PAL_LEN: len_r    <= pwdata[7:0];
          default: ;
        endcase
      end

      if (pal_we) pal_vld_r[PalAw'(in_data.entry_index)] <= 1'b1;

      if (state_r == ST_ERR) begin
        rerr_r  <= last_col ? work_t'('0) : work_t'{sh_r.right, sh_g.right, sh_b.right};
        carry_r <= (last_col || last_row) ? work_t'('0) :
                   work_t'{sh_r.diag, sh_g.diag, sh_b.diag};
        // keep what went to this column: the next pixel adds its down-left share
        prev_r  <= down_v;
      end

      // replace the result when the next pixel finishes, drop it once taken
      if (state_r == ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_OUT && out_free) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? 16'd0 : row_r + 16'd1;
        end else begin
          col_r <= col_p1[XW-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pal_rvld_r <= pal_vld_r[idx_r];
    if (accept) pix_r <= in_data;
    if (state_r == ST_SUM) begin
      work_r.r <= add_sat(pix_r.red,   rerr_r.r, nre_rdata.r);
      work_r.g <= add_sat(pix_r.green, rerr_r.g, nre_rdata.g);
      work_r.b <= add_sat(pix_r.blue,  rerr_r.b, nre_rdata.b);
      idx_r    <= '0;
    end
    if (state_r == ST_START) cur_col_r <= pal_col;
    if (state_r == ST_WAIT && dist_done) begin
      // first entry always taken, later ones only when strictly closer
      if (idx_r == '0 || dist_val < best_d_r) begin
        best_d_r   <= dist_val;
        best_idx_r <= idx_r;
        best_col_r <= cur_col_r;
      end
      if (!last_idx) idx_r <= idx_r + PalAw'(1);
    end
    if (state_r == ST_ERR) xm1_r <= '{sh_r.left, sh_g.left, sh_b.left};
    if (state_r == ST_OUT && out_free) begin
      out_r.out_red      <= best_col_r.r;
      out_r.out_green    <= best_col_r.g;
      out_r.out_blue     <= best_col_r.b;
      out_r.out_alpha    <= pix_r.alpha;
      out_r.chosen_entry <= 7'(best_idx_r);
      out_r.frame_end    <= last_col && last_row;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_WIDTH:   prdata = {19'd0, width_r};
      REG_HEIGHT:  prdata = {16'd0, height_r};
      REG_PAL_LEN: prdata = {24'd0, len_r};
      default:     prdata = '0;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  ped_ram #(.Width(48), .Depth(PalDepth)) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (PalAw'(in_data.entry_index)),
    .wdata ({in_data.red, in_data.green, in_data.blue}),
    .raddr (idx_r),
    .rdata (pal_rdata)
  );

  ped_ram #(.Width(3 * ErrW), .Depth(MaxWidth)) u_nre_ram (
    .clk   (clk),
    .we    (nre_we),
    .waddr (nre_waddr),
    .wdata (nre_wdata),
    .raddr (col_r),
    .rdata (nre_rdata)
  );

  ped_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dist_start),
    .w        (work_r),
    .p        (pal_col),
    .done     (dist_done),
    .dist_val (dist_val)
  );

endmodule

@@ sv/ped_checker.sv @@
module ped_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input ped_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input ped_pkg::out_item_t out_data
);
  import ped_pkg::*;

  // hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && out_stall) |-> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // clearing pass keeps input stalled right after reset
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> in_stall)
    else $error("input taken during clearing pass");

  a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == OP_PIXEL) |=> in_stall)
    else $error("pixel did not occupy the block");

  a_pal_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.op == OP_PAL) |=> !in_stall)
    else $error("palette write stalled input");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a pixel in work");

endmodule

bind palette_error_diffusion_dither_core ped_checker u_ped_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ped_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  palette_error_diffusion_dither_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow copy of the block's state, advanced once per accepted transaction
  logic [15:0] pal_shadow [PalDepth][3];
  int          row_err    [MaxWidth][3];
  int          right_err  [3];
  int          diag_err   [3];
  int          col_pos;
  int          row_pos;
  int          width_reg;
  int          height_reg;
  int          pal_len_reg;

  in_item_t    pixel_feed [$];
  out_item_t   dithered_q [$];
  int          mismatches;
  bit          in_took;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_request;
  int          hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the whole run
  initial begin
    #50_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int sat_err(input longint v);
    if (v > 524287) return 524287;
    if (v < -524288) return -524288;
    return int'(v);
  endfunction

  // Weighted redmean distance, scaled by 65535 and squared, exact
  function automatic logic [95:0] redmean_dist(input int wr, input int wg, input int wb,
                                               input logic [15:0] pr, input logic [15:0] pg,
                                               input logic [15:0] pb);
    longint m;
    longint dr;
    longint dg;
    longint db;
    logic [95:0] acc;
    m  = (longint'(wr) + longint'(pr)) / 2;
    dr = longint'(wr) - longint'(pr);
    dg = longint'(wg) - longint'(pg);
    db = longint'(wb) - longint'(pb);
    if (dr < 0) dr = -dr;
    if (dg < 0) dg = -dg;
    if (db < 0) db = -db;
    acc = 96'(dr * dr) * 96'(longint'(BaseWt) + m);
    acc = acc + 96'(dg * dg) * 96'(longint'(GreenWt));
    acc = acc + 96'(db * db) * 96'(longint'(BaseWt) + 65534 - m);
    return acc;
  endfunction

  function automatic void reset_shadow();
    for (int i = 0; i < PalDepth; i++)
      for (int c = 0; c < 3; c++) pal_shadow[i][c] = '0;
    for (int c = 0; c < 3; c++) pal_shadow[1][c] = 16'hFFFF;
    pal_shadow[2][0] = 16'hFFFF;
    pal_shadow[3][1] = 16'hFFFF;
    pal_shadow[4][2] = 16'hFFFF;
    for (int i = 0; i < MaxWidth; i++)
      for (int c = 0; c < 3; c++) row_err[i][c] = 0;
    for (int c = 0; c < 3; c++) begin
      right_err[c] = 0;
      diag_err[c] = 0;
    end
    col_pos = 0;
    row_pos = 0;
    width_reg = 1;
    height_reg = 1;
    pal_len_reg = 5;
  endfunction

  // Advance the shadow state by one transaction; queue the result if any
  function automatic void dither_step(input in_item_t it);
    int w;
    int h;
    int n;
    int x;
    int best;
    bit last_col;
    bit last_row;
    int work [3];
    longint d;
    logic [95:0] best_d;
    logic [95:0] dd;
    out_item_t res;
    if (it.op == OP_PAL) begin
      pal_shadow[it.entry_index][0] = it.red;
      pal_shadow[it.entry_index][1] = it.green;
      pal_shadow[it.entry_index][2] = it.blue;
      return;
    end
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MaxWidth) w = MaxWidth;
    h = (height_reg == 0) ? 1 : height_reg;
    n = (pal_len_reg == 0) ? 1 : pal_len_reg;
    if (n > PalDepth) n = PalDepth;
    x = (col_pos >= MaxWidth) ? MaxWidth - 1 : col_pos;
    last_col = (x + 1 >= w);
    last_row = (row_pos + 1 >= h);
    work[0] = sat_err(longint'(it.red) + right_err[0] + row_err[x][0]);
    work[1] = sat_err(longint'(it.green) + right_err[1] + row_err[x][1]);
    work[2] = sat_err(longint'(it.blue) + right_err[2] + row_err[x][2]);
    best = 0;
    best_d = redmean_dist(work[0], work[1], work[2],
                          pal_shadow[0][0], pal_shadow[0][1], pal_shadow[0][2]);
    for (int i = 1; i < n; i++) begin
      dd = redmean_dist(work[0], work[1], work[2],
                        pal_shadow[i][0], pal_shadow[i][1], pal_shadow[i][2]);
      if (dd < best_d) begin
        best_d = dd;
        best = i;
      end
    end
    for (int c = 0; c < 3; c++) begin
      d = longint'(work[c]) - longint'(pal_shadow[best][c]);
      right_err[c] = last_col ? 0 : sat_err(7 * d / 16);
      if (!last_row) begin
        row_err[x][c] = sat_err(5 * d / 16 + diag_err[c]);
        if (x > 0) row_err[x-1][c] = sat_err(longint'(row_err[x-1][c]) + 3 * d / 16);
        diag_err[c] = last_col ? 0 : sat_err(d / 16);
      end else begin
        row_err[x][c] = 0;
        diag_err[c] = 0;
      end
    end
    res.out_red      = pal_shadow[best][0];
    res.out_green    = pal_shadow[best][1];
    res.out_blue     = pal_shadow[best][2];
    res.out_alpha    = it.alpha;
    res.chosen_entry = 7'(best);
    res.frame_end    = last_col && last_row;
    dithered_q.push_back(res);
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) & 16'hFFFF);
    end else begin
      col_pos = x + 1;
    end
  endfunction

  // Input side: take accepted transactions into the shadow model
  always @(posedge clk) begin
    in_took = in_valid && !in_stall;
    if (rst_n && in_took) dither_step(in_data);
  end

  // Result side: compare against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (dithered_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        want = dithered_q.pop_front();
        if (want.out_red != out_data.out_red || want.out_green != out_data.out_green ||
            want.out_blue != out_data.out_blue || want.out_alpha != out_data.out_alpha ||
            want.chosen_entry != out_data.chosen_entry ||
            want.frame_end != out_data.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", want, out_data);
        end
      end
    end
  end

  // Driver: present the next pending transaction, with random gaps
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pixel_feed.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_WIDTH:   width_reg   = int'(value[12:0]);
      REG_HEIGHT:  height_reg  = int'(value[15:0]);
      REG_PAL_LEN: pal_len_reg = int'(value[7:0]);
      default: ;
    endcase
  endtask

  // Hold until every pending transaction is taken and every result is back
  task automatic drain();
    while (pixel_feed.size() != 0 || in_valid || dithered_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [15:0] chan_value();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic void push_item(input logic op, input logic [6:0] idx,
                                    input logic [15:0] r, input logic [15:0] g,
                                    input logic [15:0] b, input logic [15:0] a);
    in_item_t it;
    it.op = op;
    it.entry_index = idx;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.alpha = a;
    pixel_feed.push_back(it);
  endfunction

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
      default: begin send_idle_pct = 7; recv_stall_pct = 7; end
    endcase
  endtask

  initial begin
    int widths [10]   = '{1, 2, 3, 5, 8, 0, 4096, 8191, 7, 4};
    int heights [8]   = '{1, 2, 3, 0, 65535, 4, 6, 9};
    int pal_lens [10] = '{1, 2, 5, 8, 16, 0, 128, 255, 3, 6};
    int n_eff;
    int count;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    in_took = 1'b0;
    hold_request = 1'b0;
    hold_left = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    reset_shadow();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset palette and config, channel extremes
    push_item(OP_PIXEL, 7'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_item(OP_PIXEL, 7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_item(OP_PIXEL, 7'd0, 16'hFFFF, 16'h0000, 16'h0000, 16'h5555);
    push_item(OP_PIXEL, 7'd0, 16'h0000, 16'hFFFF, 16'h0000, 16'hAAAA);
    push_item(OP_PIXEL, 7'd0, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000);
    push_item(OP_PIXEL, 7'd0, 16'h8000, 16'h8000, 16'h8000, 16'h0001);
    drain();
    // Tie: duplicate of white above it, lowest index must win
    cfg_write(REG_PAL_LEN, 32'd6);
    cfg_write(REG_WIDTH, 32'd4);
    cfg_write(REG_HEIGHT, 32'd3);
    push_item(OP_PAL, 7'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_item(OP_PAL, 7'd127, 16'h1234, 16'hFFFF, 16'h0000, 16'hFFFF);
    for (int i = 0; i < 12; i++)
      push_item(OP_PIXEL, 7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'(i));
    drain();
    // Saturation: black-only palette with bright pixels, then white-only with dark
    cfg_write(REG_PAL_LEN, 32'd1);
    cfg_write(REG_WIDTH, 32'd8);
    cfg_write(REG_HEIGHT, 32'd40);
    for (int i = 0; i < 320; i++)
      push_item(OP_PIXEL, 7'(i), 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'(i));
    drain();
    push_item(OP_PAL, 7'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
    for (int i = 0; i < 320; i++)
      push_item(OP_PIXEL, 7'(i), 16'h0000, 16'h0000, 16'h0000, 16'(i));
    drain();

    // Random phases with mixed configs
    for (int ph = 0; ph < 16; ph++) begin
      set_mode(ph);
      cfg_write(REG_WIDTH, (ph == 15) ? 32'hFFFF_FFFF : widths[$urandom_range(9)]);
      cfg_write(REG_HEIGHT, (ph == 14) ? 32'hFFFF_0000 : heights[$urandom_range(7)]);
      cfg_write(REG_PAL_LEN, (ph == 13) ? 32'd255 : pal_lens[$urandom_range(9)]);
      n_eff = (pal_len_reg == 0) ? 1 : (pal_len_reg > PalDepth ? PalDepth : pal_len_reg);
      count = (n_eff >= 64) ? 15 : 60;
      if (ph == 5) begin
        cfg_write(REG_PAL_LEN, 32'd5);
        count = 60;
        hold_request = 1'b1;
      end
      for (int i = 0; i < count; i++) begin
        if ($urandom_range(9) == 0)
          push_item(OP_PAL, 7'($urandom_range(127)), chan_value(), chan_value(),
                    chan_value(), 16'($urandom()));
        else
          push_item(OP_PIXEL, 7'($urandom()), chan_value(), chan_value(),
                    chan_value(), 16'($urandom()));
      end
      drain();
    end

    drain();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && dithered_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ palette_error_diffusion_dither_core.f @@
sv/ped_pkg.sv
sv/ped_ram.sv
sv/ped_dist.sv
sv/palette_error_diffusion_dither_core.sv
sv/ped_checker.sv
tb/testbench.sv
